FILE: sv/ascii_encoder_reading_filter_defines.svh
// Assertion helpers for the top-level RTL file.
`ifndef ASCII_ENCODER_READING_FILTER_DEFINES_SVH
`define ASCII_ENCODER_READING_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ARF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, checked outside reset
`define ARF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: sv/arf_pkg.sv
package arf_pkg;

  localparam int RAW_W  = 16;
  localparam int FILT_W = 24;
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 16;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'd57;
  localparam logic [3:0]        DECIMAL_BASE = 4'd10;

  localparam logic [RAW_W-1:0]  RAW_MAX  = 16'hFFFF;
  localparam logic [FILT_W-1:0] FILT_MAX = 24'hFF_FFFF;

  // register defaults after reset
  localparam logic [BYTE_W-1:0] LINE_END_DEFAULT   = 8'd10;
  localparam logic [BYTE_W-1:0] STOP_STORE_DEFAULT = 8'd13;
  localparam logic [15:0]       BETA_DEFAULT       = 16'd58982;
  localparam logic [15:0]       THRESHOLD_DEFAULT  = 16'd2048;

  typedef enum logic [1:0] {
    CFG_LINE_END   = 2'd0,
    CFG_STOP_STORE = 2'd1,
    CFG_BETA       = 2'd2,
    CFG_THRESHOLD  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] beta;
    logic [15:0] threshold;
  } arf_filt_cfg_t;

endpackage

FILE: sv/arf_filter.sv
module arf_filter import arf_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic [RAW_W-1:0]  reading,
  input  logic [FILT_W-1:0] prev,
  input  arf_filt_cfg_t     cfg,
  output logic [FILT_W-1:0] filtered
);

  localparam int SW = RAW_W + FRACTION_BITS;
  localparam int CW = (SW > FILT_W) ? SW : FILT_W;

  logic [SW-1:0]        scaled_full;
  logic [FILT_W-1:0]    scaled;
  logic [CW-1:0]        limit;
  logic [FILT_W-1:0]    diff;
  logic                 jump;
  logic signed [FILT_W:0]   delta;
  logic signed [41:0]       prod;
  logic signed [41:0]       sum;
  logic [FILT_W-1:0]    smooth;

  // scale the reading into the filter format, clamp to 24 bits
  always_comb begin
    scaled_full = SW'(reading) << FRACTION_BITS;
    if (CW'(scaled_full) > CW'(FILT_MAX)) begin
      scaled = FILT_MAX;
    end else begin
      scaled = FILT_W'(scaled_full);
    end
  end

  // jump test against the threshold in whole counts
  always_comb begin
    limit = CW'(cfg.threshold) << FRACTION_BITS;
    diff  = (prev > scaled) ? (prev - scaled) : (scaled - prev);
    jump  = CW'(diff) > limit;
  end

  // beta*prev + (1-beta)*S folded into S + beta*(prev - S), rounded half up
  always_comb begin
    delta    = $signed({1'b0, prev}) - $signed({1'b0, scaled});
    prod     = delta * $signed({1'b0, cfg.beta});
    sum      = $signed({2'b00, scaled, 16'h0000}) + prod + 42'sd32768;
    smooth   = sum[39:16];
    filtered = jump ? scaled : smooth;
  end

endmodule

FILE: sv/ascii_encoder_reading_filter.sv
// ASCII encoder line reader with a jump-reset low-pass filter.
// Slave stream: one received byte per word in s_tdata. Decimal digits build
// a reading; the stop-store byte freezes it; the line-end byte emits one
// word on the master stream and clears the reading.
// Master word: m_tdata = {filtered_value, raw_value}, m_tuser = raw_saturated.
// filtered_value is Q16.FRACTION_BITS, jumping to the reading when it is more
// than jump_threshold counts away, otherwise beta*previous + (1-beta)*reading.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 line end code, 1 stop store code, 2 beta, 3 jump threshold).
// Throughput: one byte per cycle while no line-end byte waits behind an untaken
// result word. A line-end byte is held in the input register, then loaded into
// the result register with the filter update, which is one multiply-add pass.
// Reset (rst, synchronous): empty accumulator, storing enabled, filter state
// zero, registers at their defaults, no word pending.
// When the receiver stalls, the result word is held; digit and stop bytes keep
// flowing, and a further line-end byte waits in the input register, which
// then holds s_tready low until the result word is taken.
`include "ascii_encoder_reading_filter_defines.svh"

module ascii_encoder_reading_filter import arf_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,   // [15:0] raw_value, [39:16] filtered_value
  output logic [0:0]           m_tuser,   // [0] raw_saturated
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [BYTE_W-1:0] line_end_code;
  logic [BYTE_W-1:0] stop_store_code;
  arf_filt_cfg_t     filt_cfg;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_adv;
  logic              is_end;
  logic              is_stop;
  logic              is_digit;

  logic [RAW_W-1:0]  digit_acc;
  logic [RAW_W-1:0]  digit_acc_next;
  logic              acc_ovf;
  logic              acc_ovf_next;
  logic              storing;
  logic [FILT_W-1:0] prev_filt;
  logic [FILT_W-1:0] filt_next;
  logic [19:0]       acc_wide;

  logic [RAW_W-1:0]  raw_value;
  logic [FILT_W-1:0] filtered_value;
  logic              raw_saturated;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_end_code      <= LINE_END_DEFAULT;
      stop_store_code    <= STOP_STORE_DEFAULT;
      filt_cfg.beta      <= BETA_DEFAULT;
      filt_cfg.threshold <= THRESHOLD_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LINE_END:   line_end_code      <= cfg_data[BYTE_W-1:0];
        CFG_STOP_STORE: stop_store_code    <= cfg_data[BYTE_W-1:0];
        CFG_BETA:       filt_cfg.beta      <= cfg_data;
        CFG_THRESHOLD:  filt_cfg.threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify the held word; line end wins over stop store
  always_comb begin
    is_end   = in_byte == line_end_code;
    is_stop  = !is_end && (in_byte == stop_store_code);
    is_digit = !is_end && !is_stop && storing && (in_byte inside {[ASCII_ZERO:ASCII_NINE]});
    in_adv   = in_valid && (!is_end || !m_tvalid || m_tready);
    s_tready = !in_valid || in_adv;
  end

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // accumulate value*10 + digit, saturating
  always_comb begin
    acc_wide       = 20'(digit_acc) * 20'(DECIMAL_BASE) + 20'(in_byte - ASCII_ZERO);
    digit_acc_next = digit_acc;
    acc_ovf_next   = acc_ovf;
    if (acc_wide > 20'(RAW_MAX)) begin
      digit_acc_next = RAW_MAX;
      acc_ovf_next   = 1'b1;
    end else begin
      digit_acc_next = acc_wide[RAW_W-1:0];
    end
  end

  arf_filter #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_filter (
    .reading  (digit_acc),
    .prev     (prev_filt),
    .cfg      (filt_cfg),
    .filtered (filt_next)
  );

  // reading state
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_acc <= '0;
      acc_ovf   <= 1'b0;
      storing   <= 1'b1;
      prev_filt <= '0;
    end else if (in_adv) begin
      if (is_end) begin
        digit_acc <= '0;
        acc_ovf   <= 1'b0;
        storing   <= 1'b1;
        prev_filt <= filt_next;
      end else if (is_stop) begin
        storing <= 1'b0;
      end else if (is_digit) begin
        digit_acc <= digit_acc_next;
        acc_ovf   <= acc_ovf_next;
      end
    end
  end

  // result register: load on line end, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_adv && is_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && is_end) begin
      raw_value      <= digit_acc;
      filtered_value <= filt_next;
      raw_saturated  <= acc_ovf;
    end
  end

  assign m_tdata = {filtered_value, raw_value};
  assign m_tuser = raw_saturated;

  // a held input word only waits behind an untaken result
  `ARF_ASSERT_NOW(a_stall_cause, in_valid && !in_adv, is_end && m_tvalid && !m_tready)
  // line end leaves a cleared, storing accumulator
  `ARF_ASSERT_NEXT(a_end_clears, in_adv && is_end, digit_acc == '0 && !acc_ovf && storing)
  // line end always presents a result next cycle
  `ARF_ASSERT_NEXT(a_end_emits, in_adv && is_end, m_tvalid)
  // overflow flag only with a saturated accumulator
  `ARF_ASSERT_NOW(a_ovf_sat, acc_ovf, digit_acc == RAW_MAX)

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import arf_pkg::*;

  localparam int FRAC_BITS   = 8;
  localparam int DIRECT_ROWS = 25;
  localparam int PHASES      = 9;
  localparam int PHASE_BYTES = 210;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [15:0] raw;
    logic [23:0] filt;
    logic        sat;
  } reading_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       fixed;
    reading_t   want;
  } byte_row_t;

  typedef struct packed {
    logic [7:0]  line_end;
    logic [7:0]  stop_store;
    logic [15:0] beta;
    logic [15:0] threshold;
  } setting_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [BYTE_W-1:0] s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [39:0]       m_tdata;
  logic [0:0]        m_tuser;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  ascii_encoder_reading_filter #(.FRACTION_BITS(FRAC_BITS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies and reader state of the predictor
  logic [7:0]  line_end_q;
  logic [7:0]  stop_store_q;
  logic [15:0] beta_q;
  logic [15:0] thresh_q;
  logic [15:0] acc_count;
  logic        acc_clamped;
  logic        digits_open;
  logic [23:0] last_filtered;

  reading_t pending_readings[$];
  reading_t got_reading;
  reading_t want_reading;
  int       mismatches;
  int       src_gap_pct;
  int       sink_stall_pct;
  int       idle_cycles;
  int       near_reading;
  int       counted_bytes;

  // Directed bytes; expected words typed in where they follow from the reset registers
  byte_row_t direct_rows [0:DIRECT_ROWS-1] = '{
    '{LINE_END_DEFAULT, 1'b1, '{16'd0, 24'd0, 1'b0}},          // empty line
    '{"6", 1'b0, '0}, '{"5", 1'b0, '0}, '{"5", 1'b0, '0},
    '{"3", 1'b0, '0}, '{"5", 1'b0, '0},
    '{LINE_END_DEFAULT, 1'b1, '{16'd65535, 24'hFFFF00, 1'b0}}, // top reading, jump
    '{"9", 1'b0, '0}, '{"9", 1'b0, '0}, '{"9", 1'b0, '0},
    '{"9", 1'b0, '0}, '{"9", 1'b0, '0},
    '{LINE_END_DEFAULT, 1'b1, '{16'd65535, 24'hFFFF00, 1'b1}}, // clamped reading
    '{"1", 1'b0, '0}, '{"2", 1'b0, '0}, '{STOP_STORE_DEFAULT, 1'b0, '0},
    '{"3", 1'b0, '0}, '{"4", 1'b0, '0},
    '{LINE_END_DEFAULT, 1'b1, '{16'd12, 24'd3072, 1'b0}},      // digits after stop dropped
    '{"/", 1'b0, '0}, '{":", 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{"0", 1'b0, '0},
    '{LINE_END_DEFAULT, 1'b0, '0}                              // smoothing path
  };

  // Register settings per phase, defaults and extremes first; the last is randomised
  setting_t phase_settings [0:PHASES-1] = '{
    '{8'd10,  8'd13,  16'd58982, 16'd2048},
    '{8'd10,  8'd13,  16'd0,     16'd65535},
    '{8'd10,  8'd13,  16'd65535, 16'd65535},
    '{8'd10,  8'd13,  16'd40000, 16'd0},
    '{8'd0,   8'd255, 16'd32768, 16'd4096},
    '{8'd255, 8'd0,   16'd61000, 16'd1000},
    '{8'd59,  8'd59,  16'd50000, 16'd30000},
    '{"0",    "9",    16'd58982, 16'd2048},
    '{8'd10,  8'd13,  16'd0,     16'd0}
  };

  // Jump-or-smooth update of the filtered value
  function automatic logic [23:0] smooth_reading(input logic [15:0] reading);
    logic [39:0] scaled;
    logic [39:0] limit;
    logic [39:0] gap;
    logic [47:0] mix;
    scaled = 40'(reading) << FRAC_BITS;
    if (scaled > 40'(FILT_MAX)) scaled = 40'(FILT_MAX);
    limit = 40'(thresh_q) << FRAC_BITS;
    gap = (40'(last_filtered) > scaled) ? 40'(last_filtered) - scaled
                                        : scaled - 40'(last_filtered);
    if (gap > limit) begin
      mix = 48'(scaled);
    end else begin
      mix = (48'(beta_q) * 48'(last_filtered) + (48'd65536 - 48'(beta_q)) * 48'(scaled)
             + 48'd32768) >> 16;
      if (mix > 48'(FILT_MAX)) mix = 48'(FILT_MAX);
    end
    last_filtered = mix[23:0];
    return mix[23:0];
  endfunction

  // Advance the line reader by one byte; return 1 when a reading is emitted
  function automatic bit read_line_byte(input logic [7:0] rx, output reading_t r);
    logic [19:0] nxt;
    r = '0;
    if (rx == line_end_q) begin
      r.raw  = acc_count;
      r.sat  = acc_clamped;
      r.filt = smooth_reading(acc_count);
      acc_count   = '0;
      acc_clamped = 1'b0;
      digits_open = 1'b1;
      return 1'b1;
    end
    if (rx == stop_store_q) begin
      digits_open = 1'b0;
      return 1'b0;
    end
    if (digits_open && rx >= ASCII_ZERO && rx <= ASCII_NINE) begin
      nxt = 20'(acc_count) * 20'(DECIMAL_BASE) + 20'(rx - ASCII_ZERO);
      if (nxt > 20'(RAW_MAX)) begin
        nxt = 20'(RAW_MAX);
        acc_clamped = 1'b1;
      end
      acc_count = nxt[15:0];
    end
    return 1'b0;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: stall at random at each falling edge
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each result word with the oldest pending reading
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_reading = '{m_tdata[15:0], m_tdata[39:16], m_tuser[0]};
      if (pending_readings.size() == 0) begin
        $error("result word with no reading pending: raw %0d filt %0d sat %0d",
               got_reading.raw, got_reading.filt, got_reading.sat);
        mismatches++;
      end else begin
        want_reading = pending_readings.pop_front();
        if (got_reading.raw !== want_reading.raw) begin
          $error("raw_value: expected %0d, got %0d", want_reading.raw, got_reading.raw);
          mismatches++;
        end
        if (got_reading.filt !== want_reading.filt) begin
          $error("filtered_value: expected %0d, got %0d",
                 want_reading.filt, got_reading.filt);
          mismatches++;
        end
        if (got_reading.sat !== want_reading.sat) begin
          $error("raw_saturated: expected %0d, got %0d", want_reading.sat, got_reading.sat);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: stop when no word moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offer one byte, with random gaps, and predict once it is taken
  task automatic send_byte(input logic [7:0] rx, input bit fixed, input reading_t given);
    reading_t r;
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rx;
    do @(posedge clk); while (!s_tready);
    if (read_line_byte(rx, r)) pending_readings.push_back(fixed ? given : r);
    counted_bytes++;
    @(negedge clk);
  endtask

  // Hold the sender until every reading has come back and the pipeline is empty
  task automatic wait_drained(input int settle);
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  // Write all four registers; the byte codes carry random upper bits
  task automatic apply_settings(input setting_t s);
    write_reg(CFG_LINE_END,   {8'($urandom), s.line_end});
    write_reg(CFG_STOP_STORE, {8'($urandom), s.stop_store});
    write_reg(CFG_BETA,       s.beta);
    write_reg(CFG_THRESHOLD,  s.threshold);
    cfg_we <= 1'b0;
    @(negedge clk);
    line_end_q   = s.line_end;
    stop_store_q = s.stop_store;
    beta_q       = s.beta;
    thresh_q     = s.threshold;
  endtask

  // One encoder line with random content, or a short burst of noise
  task automatic send_line();
    int pick;
    int value;
    int v;
    int digs[$];
    pick = $urandom_range(99);
    if (pick >= 85) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, '0);
      return;
    end
    // pick a reading: half the time close to the last one so the smoothing path is hit
    pick = $urandom_range(99);
    if (pick < 50) begin
      value = near_reading + $urandom_range(0, 6000) - 3000;
      if (value < 0) value = 0;
      if (value > 65535) value = 65535;
    end else if (pick < 75) begin
      value = $urandom_range(0, 65535);
    end else if (pick < 85) begin
      value = $urandom_range(65536, 999999);
    end else begin
      value = $urandom_range(0, 99);
    end
    v = value;
    do begin
      digs.push_front(v % 10);
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) digs.push_front(0);
    if ($urandom_range(9) == 0) digs.delete();
    foreach (digs[i]) begin
      send_byte(ASCII_ZERO + 8'(digs[i]), 1'b0, '0);
      if ($urandom_range(19) == 0) send_byte(8'($urandom), 1'b0, '0);
    end
    // stop storing part way and trail some digits that must be dropped
    if ($urandom_range(4) == 0) begin
      send_byte(stop_store_q, 1'b0, '0);
      repeat ($urandom_range(0, 3)) begin
        send_byte(ASCII_ZERO + 8'($urandom_range(0, 9)), 1'b0, '0);
      end
    end
    send_byte(line_end_q, 1'b0, '0);
    if (value <= 65535) near_reading = value;
  endtask

  // Stimulus
  initial begin : stimulus
    setting_t s;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_LINE_END;
    cfg_data      = '0;
    mismatches    = 0;
    idle_cycles   = 0;
    counted_bytes = 0;
    near_reading  = 30000;
    src_gap_pct    = 32;
    sink_stall_pct = 55;
    line_end_q    = LINE_END_DEFAULT;
    stop_store_q  = STOP_STORE_DEFAULT;
    beta_q        = BETA_DEFAULT;
    thresh_q      = THRESHOLD_DEFAULT;
    acc_count     = '0;
    acc_clamped   = 1'b0;
    digits_open   = 1'b1;
    last_filtered = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed bytes against the reset registers
    foreach (direct_rows[i]) send_byte(direct_rows[i].rx, direct_rows[i].fixed,
                                       direct_rows[i].want);

    // random lines, one register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        src_gap_pct    = 32;
        sink_stall_pct = 55;
      end else if (p < 6) begin
        src_gap_pct    = 55;
        sink_stall_pct = 32;
      end else begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
      s = phase_settings[p];
      if (p == PHASES - 1) s = setting_t'({$urandom, $urandom});
      wait_drained(4);
      apply_settings(s);
      counted_bytes = 0;
      while (counted_bytes < PHASE_BYTES) begin
        send_line();
        if ($urandom_range(49) == 0) wait_drained(1);
      end
    end

    wait_drained(8);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
